@@ rtl/core/bcpe_pkg.sv @@
package bcpe_pkg;

    localparam int COORD_W   = 24;
    localparam int RATIO_W   = 17;
    localparam int WEIGHT_W  = 32;
    localparam int FRAC_W    = 31;
    localparam int OPND_W    = 33;
    localparam int PROD_W    = 2 * OPND_W;
    localparam int ACC_W     = 58;
    localparam int STATUS_W  = 2;
    localparam int DIV_IDX_W = 6;
    localparam int S_DATA_W  = 72;
    localparam int S_USER_W  = 2;
    localparam int M_DATA_W  = 48;
    localparam int M_USER_W  = 2;

    localparam logic [WEIGHT_W-1:0] ONE_Q31   = 32'h8000_0000;
    localparam logic [RATIO_W-1:0]  RATIO_ONE = 17'h1_0000;

    localparam logic [STATUS_W-1:0] STATUS_OK      = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_EMPTY   = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_DROPPED = 2'd2;

    localparam logic ACT_LOAD = 1'b0;
    localparam logic ACT_EVAL = 1'b1;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_UPOW_MUL,
        ST_UPOW_WR,
        ST_TERM_AB,
        ST_TERM_W,
        ST_TERM_ANEXT,
        ST_TERM_X,
        ST_TERM_Y,
        ST_ACC_Y,
        ST_BINOM_DIV,
        ST_BINOM_WR,
        ST_FINISH
    } state_t;

    typedef logic [2**DIV_IDX_W-1:0][WEIGHT_W-1:0] inv_tab_t;
    typedef logic [2**DIV_IDX_W-1:0][2:0]          shift_tab_t;

    // exact division by d: shift out the power of two, then multiply by the
    // inverse of the odd part modulo 2^32 (newton iteration at elaboration)
    function automatic inv_tab_t build_inv_tab();
        inv_tab_t     tab;
        logic [31:0]  m;
        logic [31:0]  x;
        tab = '0;
        for (int d = 1; d < 2**DIV_IDX_W; d++) begin
            m = 32'(d);
            for (int i = 0; i < DIV_IDX_W; i++) begin
                if (!m[0]) begin
                    m = m >> 1;
                end
            end
            x = m;
            for (int i = 0; i < 5; i++) begin
                x = x * (32'd2 - m * x);
            end
            tab[d] = x;
        end
        return tab;
    endfunction

    function automatic shift_tab_t build_shift_tab();
        shift_tab_t   tab;
        logic [31:0]  m;
        logic [2:0]   sh;
        tab = '0;
        for (int d = 1; d < 2**DIV_IDX_W; d++) begin
            m  = 32'(d);
            sh = 3'd0;
            for (int i = 0; i < DIV_IDX_W; i++) begin
                if (!m[0]) begin
                    m  = m >> 1;
                    sh = sh + 3'd1;
                end
            end
            tab[d] = sh;
        end
        return tab;
    endfunction

    localparam inv_tab_t   DIV_INV   = build_inv_tab();
    localparam shift_tab_t DIV_SHIFT = build_shift_tab();

endpackage

@@ rtl/core/bezier_curve_point_eval_top.sv @@
// bezier curve point evaluator, bernstein form, fixed point
//
// input stream (s_*): one beat per command
//   s_tuser[0] action: load control point or evaluate curve
//   s_tuser[1] start_new: on a load, empty the point store first
//   s_tdata holds coord_x, coord_y (signed q16.8) and ratio (q1.16, 65536 = 1.0)
// output stream (m_*): one beat per evaluate, none per load
//   m_tdata holds curve_x, curve_y (signed q16.8, saturated), m_tuser status
//
// sequencing: a load is stored while the sequencer is idle. an evaluate over
// n+1 stored points first builds the powers of (1-t) in a small table, then
// runs the term steps for each point (the last one skips the binomial update)
// and posts the result. every product goes through the one shared 33x33
// registered multiplier. an evaluate on an empty store skips to posting the
// result with status empty. s_tready is high only while the sequencer is idle,
// so a new command waits until a running evaluate has posted its result.
// when the receiver stalls, a finished result waits in the output register;
// loads are still taken, a further evaluate waits in its final step.
// reset clears the point count, the drop flag and the output valid; the
// point store itself holds garbage until written
module bezier_curve_point_eval_top #(
    parameter int MAX_POINTS = 32
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // [23:0] coord_x, [47:24] coord_y, [64:48] ratio, [71:65] zero
    input  logic [bcpe_pkg::S_DATA_W-1:0]     s_tdata,
    // [0] action, [1] start_new
    input  logic [bcpe_pkg::S_USER_W-1:0]     s_tuser,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // [23:0] curve_x, [47:24] curve_y
    output logic [bcpe_pkg::M_DATA_W-1:0]     m_tdata,
    // [1:0] status
    output logic [bcpe_pkg::M_USER_W-1:0]     m_tuser
);
    import bcpe_pkg::*;

    localparam int CNT_W = $clog2(MAX_POINTS + 1);
    localparam int IDX_W = $clog2(MAX_POINTS);

    // control state
    state_t                 state_reg, state_next;
    logic [CNT_W-1:0]       count_reg, count_next;
    logic                   ovf_reg, ovf_next;
    logic                   m_valid_reg, m_valid_next;

    // datapath registers
    logic [IDX_W-1:0]       n_reg, n_next;
    logic [IDX_W-1:0]       p_reg, p_next;
    logic [IDX_W-1:0]       k_reg, k_next;
    logic [WEIGHT_W-1:0]    tq_reg, tq_next;
    logic [WEIGHT_W-1:0]    uq_reg, uq_next;
    logic [WEIGHT_W-1:0]    a_reg, a_next;
    logic [WEIGHT_W-1:0]    ulast_reg, ulast_next;
    logic [WEIGHT_W-1:0]    w_reg, w_next;
    logic [WEIGHT_W-1:0]    binom_reg, binom_next;
    logic signed [ACC_W-1:0] accx_reg, accx_next;
    logic signed [ACC_W-1:0] accy_reg, accy_next;
    logic [STATUS_W-1:0]    status_reg, status_next;
    logic [COORD_W-1:0]     out_x_reg, out_x_next;
    logic [COORD_W-1:0]     out_y_reg, out_y_next;
    logic [STATUS_W-1:0]    out_st_reg, out_st_next;

    // point store and power-of-(1-t) table
    logic signed [COORD_W-1:0] ctrl_x_mem [MAX_POINTS];
    logic signed [COORD_W-1:0] ctrl_y_mem [MAX_POINTS];
    logic [WEIGHT_W-1:0]       upow_mem   [MAX_POINTS];
    logic signed [COORD_W-1:0] cx_rd_reg;
    logic signed [COORD_W-1:0] cy_rd_reg;
    logic [WEIGHT_W-1:0]       up_rd_reg;

    logic                   pt_we;
    logic [IDX_W-1:0]       pt_waddr;
    logic                   pt_re;
    logic                   up_we;
    logic [IDX_W-1:0]       up_waddr;
    logic [WEIGHT_W-1:0]    up_wdata;
    logic                   up_re;
    logic [IDX_W-1:0]       up_raddr;

    // shared multiplier
    logic signed [OPND_W-1:0] mul_a;
    logic signed [OPND_W-1:0] mul_b;
    logic signed [PROD_W-1:0] prod;
    logic [PROD_W-1:0]        prod_u;
    logic [WEIGHT_W-1:0]      prod_q31;
    logic [WEIGHT_W-1:0]      prod_div;
    logic [DIV_IDX_W-1:0]     div_idx;
    logic [IDX_W-1:0]         n_minus_p;

    // input fields
    logic                     accept;
    logic                     in_action;
    logic                     in_start;
    logic signed [COORD_W-1:0] in_x;
    logic signed [COORD_W-1:0] in_y;
    logic [RATIO_W-1:0]       in_ratio;
    logic [RATIO_W-1:0]       ratio_clamp;
    logic [RATIO_W-1:0]       ratio_comp;

    function automatic logic [COORD_W-1:0] sat_coord(input logic signed [ACC_W-1:0] acc);
        logic [ACC_W-FRAC_W-1:0]        q;
        logic [ACC_W-FRAC_W-COORD_W:0]  hi;
        q  = acc[ACC_W-1:FRAC_W];
        hi = q[ACC_W-FRAC_W-1:COORD_W-1];
        if ((&hi) || !(|hi)) begin
            return q[COORD_W-1:0];
        end
        else if (q[ACC_W-FRAC_W-1]) begin
            return {1'b1, {(COORD_W-1){1'b0}}};
        end
        else begin
            return {1'b0, {(COORD_W-1){1'b1}}};
        end
    endfunction

    bcpe_mult u_mult (
        .clk     (clk),
        .op_a    (mul_a),
        .op_b    (mul_b),
        .product (prod)
    );

    assign s_tready  = (state_reg == ST_IDLE);
    assign accept    = s_tvalid && s_tready;
    assign in_action = s_tuser[0];
    assign in_start  = s_tuser[1];
    assign in_x      = s_tdata[23:0];
    assign in_y      = s_tdata[47:24];
    assign in_ratio  = s_tdata[64:48];

    // a ratio above one counts as one
    assign ratio_clamp = (in_ratio > RATIO_ONE) ? RATIO_ONE : in_ratio;
    assign ratio_comp  = RATIO_ONE - ratio_clamp;

    assign prod_u    = prod;
    assign prod_q31  = prod_u[FRAC_W+WEIGHT_W-1:FRAC_W];
    assign div_idx   = DIV_IDX_W'(p_reg) + DIV_IDX_W'(1);
    assign prod_div  = WEIGHT_W'(prod_u >> DIV_SHIFT[div_idx]);
    assign n_minus_p = n_reg - p_reg;

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {out_y_reg, out_x_reg};
    assign m_tuser  = out_st_reg;

    always_comb
    begin
        state_next   = state_reg;
        count_next   = count_reg;
        ovf_next     = ovf_reg;
        m_valid_next = m_valid_reg && !m_tready;
        n_next       = n_reg;
        p_next       = p_reg;
        k_next       = k_reg;
        tq_next      = tq_reg;
        uq_next      = uq_reg;
        a_next       = a_reg;
        ulast_next   = ulast_reg;
        w_next       = w_reg;
        binom_next   = binom_reg;
        accx_next    = accx_reg;
        accy_next    = accy_reg;
        status_next  = status_reg;
        out_x_next   = out_x_reg;
        out_y_next   = out_y_reg;
        out_st_next  = out_st_reg;
        pt_we        = 1'b0;
        pt_waddr     = count_reg[IDX_W-1:0];
        pt_re        = 1'b0;
        up_we        = 1'b0;
        up_waddr     = k_reg + IDX_W'(1);
        up_wdata     = prod_q31;
        up_re        = 1'b0;
        up_raddr     = n_reg;
        mul_a        = '0;
        mul_b        = '0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept && (in_action == ACT_LOAD)) begin
                    if (in_start) begin
                        pt_we      = 1'b1;
                        pt_waddr   = '0;
                        count_next = CNT_W'(1);
                        ovf_next   = 1'b0;
                    end
                    else if (count_reg < CNT_W'(MAX_POINTS)) begin
                        pt_we      = 1'b1;
                        count_next = count_reg + CNT_W'(1);
                    end
                    else begin
                        ovf_next = 1'b1;
                    end
                end
                else if (accept) begin
                    accx_next   = '0;
                    accy_next   = '0;
                    status_next = ovf_reg ? STATUS_DROPPED : STATUS_OK;
                    if (count_reg == '0) begin
                        status_next = STATUS_EMPTY;
                        state_next  = ST_FINISH;
                    end
                    else begin
                        tq_next    = {ratio_clamp, 15'b0};
                        uq_next    = {ratio_comp, 15'b0};
                        n_next     = IDX_W'(count_reg - CNT_W'(1));
                        p_next     = '0;
                        k_next     = '0;
                        a_next     = ONE_Q31;
                        ulast_next = ONE_Q31;
                        binom_next = WEIGHT_W'(1);
                        up_we      = 1'b1;
                        up_waddr   = '0;
                        up_wdata   = ONE_Q31;
                        state_next = ST_UPOW_MUL;
                    end
                end
            end

            // build (1-t)^k for k = 0..n
            ST_UPOW_MUL:
            begin
                if (k_reg == n_reg) begin
                    up_re      = 1'b1;
                    up_raddr   = n_reg;
                    state_next = ST_TERM_AB;
                end
                else begin
                    mul_a      = $signed({1'b0, ulast_reg});
                    mul_b      = $signed({1'b0, uq_reg});
                    state_next = ST_UPOW_WR;
                end
            end

            ST_UPOW_WR:
            begin
                up_we      = 1'b1;
                up_waddr   = k_reg + IDX_W'(1);
                up_wdata   = prod_q31;
                ulast_next = prod_q31;
                k_next     = k_reg + IDX_W'(1);
                state_next = ST_UPOW_MUL;
            end

            // t^p * (1-t)^(n-p)
            ST_TERM_AB:
            begin
                mul_a      = $signed({1'b0, a_reg});
                mul_b      = $signed({1'b0, up_rd_reg});
                state_next = ST_TERM_W;
            end

            // weight = binomial * product
            ST_TERM_W:
            begin
                mul_a      = $signed({1'b0, binom_reg});
                mul_b      = $signed({1'b0, prod_q31});
                pt_re      = 1'b1;
                state_next = ST_TERM_ANEXT;
            end

            ST_TERM_ANEXT:
            begin
                w_next     = prod_u[WEIGHT_W-1:0];
                mul_a      = $signed({1'b0, a_reg});
                mul_b      = $signed({1'b0, tq_reg});
                state_next = ST_TERM_X;
            end

            ST_TERM_X:
            begin
                a_next     = prod_q31;
                mul_a      = OPND_W'(cx_rd_reg);
                mul_b      = $signed({1'b0, w_reg});
                state_next = ST_TERM_Y;
            end

            ST_TERM_Y:
            begin
                accx_next  = accx_reg + $signed(prod_u[ACC_W-1:0]);
                mul_a      = OPND_W'(cy_rd_reg);
                mul_b      = $signed({1'b0, w_reg});
                state_next = ST_ACC_Y;
            end

            ST_ACC_Y:
            begin
                accy_next = accy_reg + $signed(prod_u[ACC_W-1:0]);
                if (p_reg == n_reg) begin
                    state_next = ST_FINISH;
                end
                else begin
                    mul_a      = $signed({1'b0, binom_reg});
                    mul_b      = OPND_W'(n_minus_p);
                    up_re      = 1'b1;
                    up_raddr   = n_minus_p - IDX_W'(1);
                    state_next = ST_BINOM_DIV;
                end
            end

            // exact divide by p+1 through shift and odd inverse
            ST_BINOM_DIV:
            begin
                mul_a      = $signed({1'b0, prod_div});
                mul_b      = $signed({1'b0, DIV_INV[div_idx]});
                state_next = ST_BINOM_WR;
            end

            ST_BINOM_WR:
            begin
                binom_next = prod_u[WEIGHT_W-1:0];
                p_next     = p_reg + IDX_W'(1);
                state_next = ST_TERM_AB;
            end

            ST_FINISH:
            begin
                if (!m_valid_reg || m_tready) begin
                    m_valid_next = 1'b1;
                    out_x_next   = sat_coord(accx_reg);
                    out_y_next   = sat_coord(accy_reg);
                    out_st_next  = status_reg;
                    state_next   = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg   <= ST_IDLE;
            count_reg   <= '0;
            ovf_reg     <= 1'b0;
            m_valid_reg <= 1'b0;
        end
        else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            ovf_reg     <= ovf_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        n_reg      <= n_next;
        p_reg      <= p_next;
        k_reg      <= k_next;
        tq_reg     <= tq_next;
        uq_reg     <= uq_next;
        a_reg      <= a_next;
        ulast_reg  <= ulast_next;
        w_reg      <= w_next;
        binom_reg  <= binom_next;
        accx_reg   <= accx_next;
        accy_reg   <= accy_next;
        status_reg <= status_next;
        out_x_reg  <= out_x_next;
        out_y_reg  <= out_y_next;
        out_st_reg <= out_st_next;
    end

    // point store: one write port, read of entry p
    always_ff @(posedge clk)
    begin
        if (pt_we) begin
            ctrl_x_mem[pt_waddr] <= in_x;
            ctrl_y_mem[pt_waddr] <= in_y;
        end
        if (pt_re) begin
            cx_rd_reg <= ctrl_x_mem[p_reg];
            cy_rd_reg <= ctrl_y_mem[p_reg];
        end
    end

    // powers of (1-t)
    always_ff @(posedge clk)
    begin
        if (up_we) begin
            upow_mem[up_waddr] <= up_wdata;
        end
        if (up_re) begin
            up_rd_reg <= upow_mem[up_raddr];
        end
    end

endmodule

@@ rtl/core/bcpe_mult.sv @@
module bcpe_mult (
    input  logic                                clk,
    input  logic signed [bcpe_pkg::OPND_W-1:0]  op_a,
    input  logic signed [bcpe_pkg::OPND_W-1:0]  op_b,
    output logic signed [bcpe_pkg::PROD_W-1:0]  product
);
    import bcpe_pkg::*;

    logic signed [PROD_W-1:0] product_reg;

    // registered signed multiply, one result per cycle
    always_ff @(posedge clk)
    begin
        product_reg <= op_a * op_b;
    end

    assign product = product_reg;

endmodule

@@ rtl/core/bcpe_checker.sv @@
module bcpe_checker (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_tvalid,
    input  logic                              s_tready,
    input  logic [bcpe_pkg::S_USER_W-1:0]     s_tuser,
    input  logic                              m_tvalid,
    input  logic                              m_tready,
    input  logic [bcpe_pkg::M_DATA_W-1:0]     m_tdata,
    input  logic [bcpe_pkg::M_USER_W-1:0]     m_tuser
);
    import bcpe_pkg::*;

    // a stalled result beat holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result beat changed while stalled");

    // an accepted evaluate keeps the input closed in the next cycle
    a_eval_busy: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready && (s_tuser[0] == ACT_EVAL) |=> !s_tready)
        else $error("input ready right after an evaluate beat");

    // empty store gives a zero point
    a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tuser == STATUS_EMPTY) |-> (m_tdata == '0))
        else $error("empty status with nonzero point");

    // only defined status codes
    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tuser == STATUS_OK) || (m_tuser == STATUS_EMPTY)
                     || (m_tuser == STATUS_DROPPED))
        else $error("undefined status code");

    // a load beat never produces a result while the output was idle
    a_load_silent: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready && (s_tuser[0] == ACT_LOAD) && !m_tvalid |=> !m_tvalid)
        else $error("result beat after a load");

endmodule

bind bezier_curve_point_eval_top bcpe_checker u_bcpe_checker (.*);
